[rtl/cbsu_pkg.sv]
// ----------------------------------------------------------------------------
// cbsu_pkg
// Shared types and constants of the channel bunch sample unpacker.
// ----------------------------------------------------------------------------
package cbsu_pkg;

	localparam int QUEUE_DEPTH = 2;
	localparam int NUM_SLOTS   = 3;
	localparam int SAMPLE_W    = 10;

	// word id codes, bits 31:30
	localparam logic [1:0] ID_SAMPLE = 2'd0;
	localparam logic [1:0] ID_HEADER = 2'd1;

	// result status codes
	localparam logic [2:0] ST_SAMPLE  = 3'd0;
	localparam logic [2:0] ST_BAD_HDR = 3'd1;
	localparam logic [2:0] ST_BAD_SMP = 3'd2;
	localparam logic [2:0] ST_BAD_LEN = 3'd3;
	localparam logic [2:0] ST_TRUNC   = 3'd4;

	typedef enum logic [1:0] {
		KIND_SAMPLE,
		KIND_HEADER,
		KIND_BAD
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] word;
		logic        lastw;
	} word_t;

	typedef struct packed {
		logic [2:0]          status;
		logic [11:0]         addr;
		logic                err;
		logic [11:0]         btime;
		logic [SAMPLE_W-1:0] idx;
		logic [SAMPLE_W-1:0] val;
		logic                last;
	} res_t;

	typedef struct packed {
		logic [NUM_SLOTS-1:0]  mask;
		res_t [NUM_SLOTS-1:0]  res;
	} batch_t;

endpackage

[rtl/cbsu_front.sv]
// ----------------------------------------------------------------------------
// cbsu_front
// Input register: takes payload words and tags each with its word kind.
// ----------------------------------------------------------------------------
module cbsu_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             word_valid,
	output logic             word_stall,
	input  logic [31:0]      data_word,
	input  logic             last_word,
	output logic             push_valid,
	input  logic             push_ready,
	output cbsu_pkg::word_t  push_data
);

	logic            valid_s1;
	cbsu_pkg::word_t ent_s1;
	cbsu_pkg::kind_t kind;

	always_comb begin
		unique case (data_word[31:30])
			cbsu_pkg::ID_SAMPLE: kind = cbsu_pkg::KIND_SAMPLE;
			cbsu_pkg::ID_HEADER: kind = cbsu_pkg::KIND_HEADER;
			default:             kind = cbsu_pkg::KIND_BAD;
		endcase
	end

	assign word_stall = valid_s1 && !push_ready;
	assign push_valid = valid_s1;
	assign push_data  = ent_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!word_stall) begin
			valid_s1 <= word_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!word_stall && word_valid) begin
			ent_s1.kind  <= kind;
			ent_s1.word  <= data_word;
			ent_s1.lastw <= last_word;
		end
	end

endmodule

[rtl/cbsu_queue.sv]
// ----------------------------------------------------------------------------
// cbsu_queue
// Short register queue between the front and the decoder.
// ----------------------------------------------------------------------------
module cbsu_queue #(
	parameter int Depth = cbsu_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  cbsu_pkg::word_t  push_data,
	output logic             pop_valid,
	input  logic             pop_en,
	output cbsu_pkg::word_t  pop_data
);

	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CW = $clog2(Depth + 1);

	cbsu_pkg::word_t mem_q [Depth];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   cnt_q;
	logic            push;
	logic            pop;

	assign push_ready = (cnt_q != CW'(Depth));
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_en && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				if (wr_ptr_q == AW'(Depth - 1)) wr_ptr_q <= '0;
				else wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				if (rd_ptr_q == AW'(Depth - 1)) rd_ptr_q <= '0;
				else rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

[rtl/cbsu_decode.sv]
// ----------------------------------------------------------------------------
// cbsu_decode
// Channel/bunch state machine: decodes one queued word per cycle, unless the
// serializer still holds a batch, into a batch of up to three results.
// ----------------------------------------------------------------------------
module cbsu_decode (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  cbsu_pkg::word_t  q_data,
	output logic             q_pop,
	output logic             batch_valid,
	input  logic             batch_ready,
	output cbsu_pkg::batch_t batch
);

	localparam int SW = cbsu_pkg::SAMPLE_W;

	logic          in_ch_q;
	logic [11:0]   addr_q;
	logic          err_q;
	logic [SW-1:0] sl_q;
	logic [SW-1:0] bp_q;
	logic [SW-1:0] bl_q;
	logic [SW-1:0] bt_q;

	logic          n_in;
	logic [11:0]   n_addr;
	logic          n_err;
	logic [SW-1:0] n_sl;
	logic [SW-1:0] n_bp;
	logic [SW-1:0] n_bl;
	logic [SW-1:0] n_bt;
	logic [2:0]    mask;
	cbsu_pkg::res_t [cbsu_pkg::NUM_SLOTS-1:0] res;

	always_comb begin
		logic [1:0]    use_n;
		logic          stop;
		logic          fin;
		logic          is_data;
		logic [SW-1:0] s;
		logic [SW-1:0] idx;

		n_in   = in_ch_q;
		n_addr = addr_q;
		n_err  = err_q;
		n_sl   = sl_q;
		n_bp   = bp_q;
		n_bl   = bl_q;
		n_bt   = bt_q;
		mask   = '0;
		res    = '0;
		stop   = 1'b0;
		fin    = 1'b0;
		is_data = 1'b0;
		s      = '0;
		idx    = '0;
		use_n  = (sl_q < SW'(3)) ? sl_q[1:0] : 2'd3;

		if (!in_ch_q) begin
			if (q_data.kind != cbsu_pkg::KIND_HEADER) begin
				mask[0]          = 1'b1;
				res[0].status    = cbsu_pkg::ST_BAD_HDR;
			end else begin
				n_addr = q_data.word[11:0];
				n_err  = q_data.word[29];
				n_sl   = q_data.word[25:16];
				n_bp   = '0;
				n_in   = (n_sl != '0);
				// payload ends right after the header
				if (q_data.lastw && n_in) begin
					mask[0]       = 1'b1;
					res[0].status = cbsu_pkg::ST_TRUNC;
					res[0].addr   = n_addr;
					res[0].err    = n_err;
				end
			end
		end else if (q_data.kind != cbsu_pkg::KIND_SAMPLE) begin
			mask[0]       = 1'b1;
			res[0].status = cbsu_pkg::ST_BAD_SMP;
			res[0].addr   = addr_q;
			res[0].err    = err_q;
			n_in = 1'b0;
			n_sl = '0;
			n_bp = '0;
		end else begin
			for (int k = 0; k < cbsu_pkg::NUM_SLOTS; k++) begin
				if (!stop && (2'(k) < use_n)) begin
					s       = q_data.word[20 - 10*k +: SW];
					fin     = (2'(k + 1) == use_n);
					is_data = 1'b0;
					idx     = '0;
					n_sl    = n_sl - 1'b1;
					if (n_bp == '0) begin
						if (s < SW'(2)) begin
							mask[k]       = 1'b1;
							res[k].status = cbsu_pkg::ST_BAD_LEN;
							res[k].addr   = n_addr;
							res[k].err    = n_err;
							n_in = 1'b0;
							n_sl = '0;
							n_bp = '0;
							stop = 1'b1;
						end else begin
							n_bl = s;
							n_bp = SW'(1);
						end
					end else if (n_bp == SW'(1)) begin
						n_bt = s;
						n_bp = SW'(2);
					end else begin
						is_data = 1'b1;
						idx     = n_bl - 1'b1 - n_bp;
						n_bp    = n_bp + 1'b1;
					end
					if (!stop) begin
						if (n_bp == n_bl) n_bp = '0;
						// channel or payload ends inside a bunch
						if (fin && (((n_sl == '0) && (n_bp != '0)) ||
						            (q_data.lastw && (n_sl != '0)))) begin
							mask[k]       = 1'b1;
							res[k].status = cbsu_pkg::ST_TRUNC;
							res[k].addr   = n_addr;
							res[k].err    = n_err;
							n_in = 1'b0;
							n_sl = '0;
							n_bp = '0;
							stop = 1'b1;
						end else if (is_data) begin
							mask[k]       = 1'b1;
							res[k].status = cbsu_pkg::ST_SAMPLE;
							res[k].addr   = n_addr;
							res[k].err    = n_err;
							res[k].btime  = {2'b00, n_bt} + 12'd1 - {2'b00, n_bl};
							res[k].idx    = idx;
							res[k].val    = s;
						end
					end
				end
			end
			if (n_sl == '0) begin
				n_in = 1'b0;
				n_bp = '0;
			end
		end

		if (q_data.lastw) begin
			n_in = 1'b0;
			n_sl = '0;
			n_bp = '0;
		end

		res[2].last = mask[2];
		res[1].last = mask[1] && !mask[2];
		res[0].last = mask[0] && !mask[1] && !mask[2];
	end

	assign batch_valid = q_valid && (mask != '0);
	assign q_pop       = q_valid && (batch_ready || (mask == '0));
	assign batch.mask  = mask;
	assign batch.res   = res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch_q <= 1'b0;
			addr_q  <= '0;
			err_q   <= 1'b0;
			sl_q    <= '0;
			bp_q    <= '0;
			bl_q    <= '0;
			bt_q    <= '0;
		end else if (q_pop) begin
			in_ch_q <= n_in;
			addr_q  <= n_addr;
			err_q   <= n_err;
			sl_q    <= n_sl;
			bp_q    <= n_bp;
			bl_q    <= n_bl;
			bt_q    <= n_bt;
		end
	end

endmodule

[rtl/cbsu_emit.sv]
// ----------------------------------------------------------------------------
// cbsu_emit
// Result serializer: holds one batch and sends its results one per cycle,
// while the receiver does not stall, through the output register.
// ----------------------------------------------------------------------------
module cbsu_emit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             batch_valid,
	output logic             batch_ready,
	input  cbsu_pkg::batch_t batch,
	output logic             result_valid,
	input  logic             result_stall,
	output cbsu_pkg::res_t   result
);

	cbsu_pkg::res_t slot_q [cbsu_pkg::NUM_SLOTS];
	logic [2:0]     rem_q;
	logic           out_valid_q;
	cbsu_pkg::res_t out_q;
	logic           free;
	logic [1:0]     rem_sel;
	logic [1:0]     b_sel;

	function automatic logic [1:0] first_set(input logic [2:0] m);
		if (m[0]) return 2'd0;
		else if (m[1]) return 2'd1;
		else return 2'd2;
	endfunction

	assign free         = !out_valid_q || !result_stall;
	assign batch_ready  = free && (rem_q == '0);
	assign rem_sel      = first_set(rem_q);
	assign b_sel        = first_set(batch.mask);
	assign result_valid = out_valid_q;
	assign result       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			rem_q       <= '0;
		end else if (free) begin
			if (rem_q != '0) begin
				out_valid_q <= 1'b1;
				rem_q       <= rem_q & ~(3'b001 << rem_sel);
			end else if (batch_valid) begin
				out_valid_q <= 1'b1;
				rem_q       <= batch.mask & ~(3'b001 << b_sel);
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (free) begin
			if (rem_q != '0) begin
				out_q <= slot_q[rem_sel];
			end else if (batch_valid) begin
				out_q <= batch.res[b_sel];
				for (int i = 0; i < cbsu_pkg::NUM_SLOTS; i++) begin
					slot_q[i] <= batch.res[i];
				end
			end
		end
	end

endmodule

[rtl/channel_bunch_sample_unpacker_core.sv]
// ----------------------------------------------------------------------------
// channel_bunch_sample_unpacker_core
// Decodes zero-suppressed bunch-format payload words into per-sample results.
// ----------------------------------------------------------------------------
// Usage:
//   Word channel: data_word/last_word, moved when word_valid is high and
//   word_stall is low. Result channel: status, channel fields, bunch_time,
//   sample_index, sample_value and last, moved when result_valid is high and
//   result_stall is low. last marks the final result of one input word.
//   A word enters an input register, passes a short queue and is decoded
//   combinationally into up to three results, which leave one per cycle
//   through the output register while the receiver does not stall.
//   The first result of a word passes the input register, the queue and
//   the output register. The serializer takes a new word's results only
//   once it has sent all results of the one before; a word with no result
//   is popped from the queue without entering it.
//   The serializer's rate of one result per cycle limits throughput.
//   Reset: the decoder waits for a channel header and no channel is open.
//   When the receiver stalls, the output holds; the queue and input register
//   keep taking words until full, then word_stall is raised.
// ----------------------------------------------------------------------------
module channel_bunch_sample_unpacker_core #(
	parameter int QUEUE_DEPTH = cbsu_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               word_valid,
	output logic               word_stall,
	input  logic [31:0]        data_word,
	input  logic               last_word,
	output logic               result_valid,
	input  logic               result_stall,
	output logic [2:0]         status,
	output logic [11:0]        channel_address,
	output logic               channel_error,
	output logic signed [11:0] bunch_time,
	output logic [9:0]         sample_index,
	output logic [9:0]         sample_value,
	output logic               last
);

	logic             push_valid;
	logic             push_ready;
	cbsu_pkg::word_t  push_data;
	logic             q_valid;
	logic             q_pop;
	cbsu_pkg::word_t  q_data;
	logic             batch_valid;
	logic             batch_ready;
	cbsu_pkg::batch_t batch;
	cbsu_pkg::res_t   result;

	cbsu_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.word_valid (word_valid),
		.word_stall (word_stall),
		.data_word  (data_word),
		.last_word  (last_word),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	cbsu_queue #(
		.Depth (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (q_valid),
		.pop_en     (q_pop),
		.pop_data   (q_data)
	);

	cbsu_decode u_decode (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_data      (q_data),
		.q_pop       (q_pop),
		.batch_valid (batch_valid),
		.batch_ready (batch_ready),
		.batch       (batch)
	);

	cbsu_emit u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.batch_valid  (batch_valid),
		.batch_ready  (batch_ready),
		.batch        (batch),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	assign status          = result.status;
	assign channel_address = result.addr;
	assign channel_error   = result.err;
	assign bunch_time      = result.btime;
	assign sample_index    = result.idx;
	assign sample_value    = result.val;
	assign last            = result.last;

endmodule

[tb/channel_bunch_sample_unpacker_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// channel_bunch_sample_unpacker_checker
// Watches the word and result channels of the unpacker. It decodes every
// accepted word on its own, queues the results that the word should give,
// and compares each accepted result field by field with the oldest one.
// ----------------------------------------------------------------------------
module channel_bunch_sample_unpacker_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               word_valid,
	input  logic               word_stall,
	input  logic [31:0]        data_word,
	input  logic               last_word,
	input  logic               result_valid,
	input  logic               result_stall,
	input  logic [2:0]         status,
	input  logic [11:0]        channel_address,
	input  logic               channel_error,
	input  logic signed [11:0] bunch_time,
	input  logic [9:0]         sample_index,
	input  logic [9:0]         sample_value,
	input  logic               last,
	output int                 errors,
	output int                 outstanding
);

	cbsu_pkg::res_t decoded_q[$];

	// decoder state
	bit         chan_open = 0;
	logic [11:0] cur_addr = '0;
	logic        cur_err  = 1'b0;
	logic [9:0]  left     = '0;
	logic [9:0]  pos      = '0;
	logic [9:0]  blen     = '0;
	logic [9:0]  btraw    = '0;

	int fail_cnt = 0;

	function automatic cbsu_pkg::res_t make_res(logic [2:0] st, logic [11:0] bt,
			logic [9:0] ix, logic [9:0] v);
		cbsu_pkg::res_t r;
		r.status = st;
		r.addr   = (st == cbsu_pkg::ST_BAD_HDR) ? 12'd0 : cur_addr;
		r.err    = (st == cbsu_pkg::ST_BAD_HDR) ? 1'b0 : cur_err;
		r.btime  = bt;
		r.idx    = ix;
		r.val    = v;
		r.last   = 1'b0;
		return r;
	endfunction

	function automatic void close_chan();
		chan_open = 0;
		left = '0;
		pos = '0;
	endfunction

	function automatic void unpack_word(logic [31:0] w, logic lw);
		cbsu_pkg::res_t batch[$];
		int             take;
		int             k;
		logic [9:0]     s;
		logic [9:0]     ix;
		bit             fin;
		bit             is_data;
		if (!chan_open) begin
			if (w[31:30] != cbsu_pkg::ID_HEADER) begin
				batch = {batch, make_res(cbsu_pkg::ST_BAD_HDR, '0, '0, '0)};
			end else begin
				cur_addr = w[11:0];
				cur_err = w[29];
				left = w[25:16];
				pos = '0;
				chan_open = (left != 0);
				if (lw && chan_open)
					batch = {batch, make_res(cbsu_pkg::ST_TRUNC, '0, '0, '0)};
			end
		end else if (w[31:30] != cbsu_pkg::ID_SAMPLE) begin
			batch = {batch, make_res(cbsu_pkg::ST_BAD_SMP, '0, '0, '0)};
			close_chan();
		end else begin
			take = (left < 3) ? int'(left) : 3;
			for (k = 0; k < take; k++) begin
				s = w[20 - 10*k +: 10];
				fin = (k + 1 == take);
				is_data = 0;
				ix = '0;
				left = left - 10'd1;
				if (pos == 0) begin
					if (s < 2) begin
						batch = {batch, make_res(cbsu_pkg::ST_BAD_LEN, '0, '0, '0)};
						close_chan();
						break;
					end
					blen = s;
					pos = 10'd1;
				end else if (pos == 1) begin
					btraw = s;
					pos = 10'd2;
				end else begin
					is_data = 1;
					ix = blen - 10'd1 - pos;
					pos = pos + 10'd1;
				end
				if (pos == blen)
					pos = '0;
				// channel ends mid-bunch, or payload ends with samples still owed
				if (fin && ((left == 0 && pos != 0) || (lw && left != 0))) begin
					batch = {batch, make_res(cbsu_pkg::ST_TRUNC, '0, '0, '0)};
					close_chan();
					break;
				end
				if (is_data)
					batch = {batch, make_res(cbsu_pkg::ST_SAMPLE,
						{2'b00, btraw} + 12'd1 - {2'b00, blen}, ix, s)};
			end
			if (left == 0)
				close_chan();
		end
		if (lw)
			close_chan();
		if (batch.size() > 0)
			batch[batch.size() - 1].last = 1'b1;
		decoded_q = {decoded_q, batch};
	endfunction

	always @(posedge clk) begin : watch
		cbsu_pkg::res_t got;
		cbsu_pkg::res_t want;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				got.status = status;
				got.addr   = channel_address;
				got.err    = channel_error;
				got.btime  = bunch_time;
				got.idx    = sample_index;
				got.val    = sample_value;
				got.last   = last;
				if (decoded_q.size() == 0) begin
					fail_cnt++;
					if (fail_cnt <= 10)
						$display("%0t: result with none expected: st=%0d addr=%h err=%0d",
							$realtime, got.status, got.addr, got.err);
				end else begin
					want = decoded_q.pop_front();
					if (got.status !== want.status || got.addr !== want.addr ||
							got.err !== want.err || got.btime !== want.btime ||
							got.idx !== want.idx || got.val !== want.val ||
							got.last !== want.last) begin
						fail_cnt++;
						if (fail_cnt <= 10) begin
							$display("%0t: mismatch", $realtime);
							$display("  expected st=%0d addr=%h err=%0d time=%0d idx=%0d val=%0d last=%0d",
								want.status, want.addr, want.err, $signed(want.btime),
								want.idx, want.val, want.last);
							$display("  actual   st=%0d addr=%h err=%0d time=%0d idx=%0d val=%0d last=%0d",
								got.status, got.addr, got.err, $signed(got.btime),
								got.idx, got.val, got.last);
						end
					end
				end
			end
			if (word_valid && !word_stall)
				unpack_word(data_word, last_word);
		end
		errors <= fail_cnt;
		outstanding <= decoded_q.size();
	end

endmodule

[tb/channel_bunch_sample_unpacker_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// channel_bunch_sample_unpacker_core_tb
// Feeds payload words to the unpacker: a directed set of corner cases, then
// random channels of well-formed bunches with faults mixed in, under random
// idling on both sides. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module channel_bunch_sample_unpacker_core_tb;

	localparam logic [1:0] ID_SPARE_A = 2'd2;
	localparam logic [1:0] ID_SPARE_B = 2'd3;
	localparam int IDLE_LIMIT = 3000;
	localparam int HOLD_CYCLES = 300;

	typedef enum int {
		FAULT_NONE,
		FAULT_SHORT_LEN,
		FAULT_CUT,
		FAULT_BAD_ID,
		FAULT_EARLY_LAST
	} fault_t;

	logic               clk;
	logic               arst_n;
	logic               word_valid;
	logic               word_stall;
	logic [31:0]        data_word;
	logic               last_word;
	logic               result_valid;
	logic               result_stall;
	logic [2:0]         status;
	logic [11:0]        channel_address;
	logic               channel_error;
	logic signed [11:0] bunch_time;
	logic [9:0]         sample_index;
	logic [9:0]         sample_value;
	logic               last;

	int errors;
	int outstanding;
	int words_sent = 0;
	int idle_cycles = 0;
	bit calm = 0;
	bit hold_req = 0;

	channel_bunch_sample_unpacker_core uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.word_valid      (word_valid),
		.word_stall      (word_stall),
		.data_word       (data_word),
		.last_word       (last_word),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.status          (status),
		.channel_address (channel_address),
		.channel_error   (channel_error),
		.bunch_time      (bunch_time),
		.sample_index    (sample_index),
		.sample_value    (sample_value),
		.last            (last)
	);

	channel_bunch_sample_unpacker_checker chk (
		.clk             (clk),
		.arst_n          (arst_n),
		.word_valid      (word_valid),
		.word_stall      (word_stall),
		.data_word       (data_word),
		.last_word       (last_word),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.status          (status),
		.channel_address (channel_address),
		.channel_error   (channel_error),
		.bunch_time      (bunch_time),
		.sample_index    (sample_index),
		.sample_value    (sample_value),
		.last            (last),
		.errors          (errors),
		.outstanding     (outstanding)
	);

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		word_valid = 1'b0;
		data_word = '0;
		last_word = 1'b0;
		result_stall = 1'b0;
	end

	always #5 clk = ~clk;

	// header with random filler in the unused bits
	function automatic logic [31:0] hdr(logic [11:0] addr, logic err, logic [9:0] cnt);
		logic [31:0] r;
		r = $urandom;
		return {cbsu_pkg::ID_HEADER, err, r[2:0], cnt, r[6:3], addr};
	endfunction

	function automatic logic [31:0] smp3(logic [9:0] a, logic [9:0] b, logic [9:0] c);
		return {cbsu_pkg::ID_SAMPLE, a, b, c};
	endfunction

	task automatic send_word(input logic [31:0] w, input logic lw);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			word_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		word_valid <= 1'b1;
		data_word <= w;
		last_word <= lw;
		do @(posedge clk); while (word_stall);
		words_sent++;
	endtask

	// one channel of random bunches, optionally broken in one way
	task automatic send_channel(input fault_t fault);
		logic [9:0]  seq[$];
		int          starts[$];
		int          nb, len, b, d, cnt, nw, i, p, stop_w, early_w, drop;
		logic        lw_end, lw;
		logic [9:0]  s0, s1, s2;
		logic [31:0] w;
		nb = $urandom_range(0, 4);
		len = 0;
		for (b = 0; b < nb; b++) begin
			starts = {starts, seq.size()};
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(2, 60) : $urandom_range(2, 8);
			seq = {seq, 10'(len)};
			seq = {seq, 10'($urandom_range(0, 1023))};
			for (d = 2; d < len; d++)
				seq = {seq, 10'($urandom_range(0, 1023))};
		end
		starts = {starts, seq.size()};
		stop_w = -2;
		early_w = -2;
		case (fault)
			FAULT_SHORT_LEN: begin
				p = starts[$urandom_range(0, starts.size() - 1)];
				seq.insert(p, $urandom_range(0, 1));
				stop_w = p / 3;
			end
			FAULT_CUT: begin
				if (nb > 0) begin
					drop = $urandom_range(1, len - 1);
					repeat (drop) void'(seq.pop_back());
				end
			end
			default: ;
		endcase
		cnt = seq.size();
		nw = (cnt + 2) / 3;
		if (fault == FAULT_BAD_ID && nw > 0)
			stop_w = $urandom_range(0, nw - 1);
		if (fault == FAULT_EARLY_LAST)
			early_w = $urandom_range(0, nw) - 1;
		lw_end = ($urandom_range(0, 3) == 0);
		lw = (early_w == -1) || (cnt == 0 && lw_end);
		send_word(hdr($urandom_range(0, 4095), $urandom_range(0, 1), cnt), lw);
		if (lw && cnt > 0)
			return;
		for (i = 0; i < nw; i++) begin
			s0 = (3*i < cnt) ? seq[3*i] : 10'($urandom_range(0, 1023));
			s1 = (3*i + 1 < cnt) ? seq[3*i + 1] : 10'($urandom_range(0, 1023));
			s2 = (3*i + 2 < cnt) ? seq[3*i + 2] : 10'($urandom_range(0, 1023));
			w = smp3(s0, s1, s2);
			if (fault == FAULT_BAD_ID && i == stop_w)
				w[31:30] = ($urandom_range(0, 2) == 0) ? cbsu_pkg::ID_HEADER :
					($urandom_range(0, 1) ? ID_SPARE_A : ID_SPARE_B);
			lw = (i == nw - 1) ? lw_end : (i == early_w);
			send_word(w, lw);
			if (i == stop_w || lw)
				break;
		end
	endtask

	task automatic random_until(input int target);
		int r;
		fault_t f;
		while (words_sent < target) begin
			if ($urandom_range(0, 99) < 8) begin
				send_word($urandom, $urandom_range(0, 1));
			end else begin
				r = $urandom_range(0, 99);
				if (r < 55)
					f = FAULT_NONE;
				else if (r < 66)
					f = FAULT_SHORT_LEN;
				else if (r < 77)
					f = FAULT_CUT;
				else if (r < 88)
					f = FAULT_BAD_ID;
				else
					f = FAULT_EARLY_LAST;
				send_channel(f);
			end
		end
	endtask

	// result side
	initial begin : receiver
		int stall_for;
		bit hold_taken;
		@(posedge clk);
		forever begin
			if (hold_req && !hold_taken) begin
				stall_for = HOLD_CYCLES;
				hold_taken = 1;
			end else begin
				stall_for = calm ? 0 : $urandom_range(0, 17);
			end
			if (stall_for > 0) begin
				result_stall <= 1'b1;
				repeat (stall_for) @(posedge clk);
			end
			result_stall <= 1'b0;
			do @(posedge clk); while (!result_valid);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((word_valid && !word_stall) || (result_valid && !result_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("channel_bunch_sample_unpacker_core test failed");
				$finish;
			end
		end
	end

	initial begin : stimulus
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// no channel open: anything but a header is an error
		send_word({cbsu_pkg::ID_SAMPLE, 30'h2AAAAAAA}, 1'b0);
		send_word({ID_SPARE_A, 30'h3FFFFFFF}, 1'b0);
		send_word({ID_SPARE_B, 30'h00000000}, 1'b1);
		// empty channel, then payload ends right after a header
		send_word(hdr(12'hFFF, 1'b1, 10'd0), 1'b0);
		send_word(hdr(12'h000, 1'b0, 10'd5), 1'b1);
		// short bunch with no data, then a bunch of length five; unused tail ignored
		send_word(hdr(12'hFFF, 1'b1, 10'd7), 1'b0);
		send_word(smp3(10'd2, 10'd1023, 10'd5), 1'b0);
		send_word(smp3(10'd0, 10'd1023, 10'd0), 1'b0);
		send_word(smp3(10'h2AA, 10'h155, 10'h3FF), 1'b1);
		// longest bunch, earliest time; payload ends with samples owed
		send_word(hdr(12'hA5A, 1'b0, 10'd1023), 1'b0);
		send_word(smp3(10'd1023, 10'd0, 10'h155), 1'b0);
		send_word(smp3(10'h3FF, 10'h000, 10'h2AA), 1'b1);
		// near-latest time, then bunch length one
		send_word(hdr(12'h5A5, 1'b1, 10'd6), 1'b0);
		send_word(smp3(10'd3, 10'd1023, 10'h3FF), 1'b0);
		send_word(smp3(10'd1, 10'd9, 10'd9), 1'b0);
		// bunch length zero
		send_word(hdr(12'h001, 1'b0, 10'd4), 1'b0);
		send_word(smp3(10'd0, 10'd4, 10'd4), 1'b0);
		// bad id inside a channel, spare id and header id
		send_word(hdr(12'h002, 1'b0, 10'd9), 1'b0);
		send_word(smp3(10'd2, 10'd5, 10'd3), 1'b0);
		send_word({ID_SPARE_A, 30'h15555555}, 1'b0);
		send_word(hdr(12'h003, 1'b1, 10'd3), 1'b0);
		send_word(hdr(12'h004, 1'b0, 10'd3), 1'b0);
		// count ends inside a bunch
		send_word(hdr(12'h007, 1'b0, 10'd5), 1'b0);
		send_word(smp3(10'd4, 10'd100, 10'd7), 1'b0);
		send_word(smp3(10'd8, 10'd6, 10'd1), 1'b0);

		// sender pauses until everything has drained; the count is registered
		word_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);

		random_until(115);
		// receiver holds off while words keep coming
		hold_req = 1;
		calm = 1;
		random_until(175);
		calm = 0;
		random_until(280);

		word_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0 && outstanding == 0)
			$display("channel_bunch_sample_unpacker_core test passed");
		else
			$display("channel_bunch_sample_unpacker_core test failed");
		$finish;
	end

endmodule
